@@ rtl/fcrp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the font command record parser.
// No dependencies.
package fcrp_pkg;

    localparam logic [2:0] CMD_START      = 3'd0;
    localparam logic [2:0] CMD_SET_GLYPH  = 3'd1;
    localparam logic [2:0] CMD_ASCII_SIZE = 3'd2;
    localparam logic [2:0] CMD_KANJI_SIZE = 3'd3;

    localparam logic [3:0] STS_GLYPH_STORED = 4'd0;
    localparam logic [3:0] STS_SIZE_SET     = 4'd1;
    localparam logic [3:0] STS_CODE_IGNORED = 4'd2;
    localparam logic [3:0] STS_SHORT_RECORD = 4'd3;
    localparam logic [3:0] STS_ZERO_SIZE    = 4'd4;
    localparam logic [3:0] STS_SIZE_CONFLICT = 4'd5;
    localparam logic [3:0] STS_SIZE_UNDEF   = 4'd6;
    localparam logic [3:0] STS_PAYLOAD_SHORT = 4'd7;
    localparam logic [3:0] STS_BAD_COMMAND  = 4'd8;
    localparam logic [3:0] STS_HALTED       = 4'd9;
    localparam logic [3:0] STS_STARTED      = 4'd10;

    localparam int HEADER_BYTES      = 6;
    localparam int SINGLE_BYTE_LIMIT = 256;

    // One classified record, handed from the front part to the back part.
    typedef struct packed {
        logic        is_start;
        logic        slot_write;
        logic [3:0]  status;
        logic [15:0] slot;
        logic [31:0] glyph_ref;
    } t_entry;

endpackage

@@ rtl/fcrp_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module fcrp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fcrp_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue of classified records between the front and back parts.
// Depends on fcrp_pkg.
module fcrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fcrp_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output fcrp_pkg::t_entry o_data
);

    fcrp_pkg::t_entry r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/fcrp_front.sv @@
`timescale 1ns / 1ps
// Front part: accepts records, keeps sizes and the halt flag, and classifies
// each record into a status and a table slot. Depends on fcrp_pkg.
module fcrp_front #(
    parameter int SLOT_COUNT = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0]       i_cmd,
    input  logic [15:0]      i_arg,
    input  logic [15:0]      i_record_len,
    input  logic [31:0]      i_glyph_ref,
    input  logic             i_q_full,
    output logic             o_push,
    output fcrp_pkg::t_entry o_entry
);

    logic [7:0] r_ascii_w, r_ascii_h, r_kanji_w, r_kanji_h;
    logic       r_halted;
    logic [7:0] n_ascii_w, n_ascii_h, n_kanji_w, n_kanji_h;
    logic       n_halted;

    logic        single;
    logic [7:0]  sel_w, sel_h;
    logic [5:0]  row_bytes;
    logic [13:0] need;
    logic        payload_short;
    logic [7:0]  hi, lo, hi_s, lo_s;
    logic        jis_ok;
    logic [15:0] code;
    logic        code_fits;
    logic [7:0]  sx, sy;
    logic [7:0]  cur_w, cur_h;

    assign o_ready = ~i_q_full;
    assign o_push  = i_valid & ~i_q_full;

    always_comb begin
        single    = {1'b0, i_arg} < 17'(fcrp_pkg::SINGLE_BYTE_LIMIT);
        sel_w     = single ? r_ascii_w : r_kanji_w;
        sel_h     = single ? r_ascii_h : r_kanji_h;
        row_bytes = 6'(({1'b0, sel_w} + 9'd7) >> 3);
        need      = 14'(row_bytes) * 14'(sel_h);
        payload_short = {1'b0, i_record_len}
                        < (17'(need) + 17'(fcrp_pkg::HEADER_BYTES));

        hi = i_arg[15:8];
        lo = i_arg[7:0];
        jis_ok = (lo >= 8'h21) && (lo <= 8'h7e)
                 && (((hi >= 8'h21) && (hi <= 8'h7e)) || ((hi >= 8'h93) && (hi <= 8'h97)));
        if (hi[0]) begin
            lo_s = lo + 8'h1f;
            if (lo_s >= 8'h7f) begin
                lo_s = lo_s + 8'd1;
            end
        end else begin
            lo_s = lo + 8'h7e;
        end
        hi_s = ((hi - 8'd1) >> 1) + ((hi < 8'h5f) ? 8'h71 : 8'hb1);
        code = single ? i_arg : {hi_s, lo_s};
        code_fits = {1'b0, code} < 17'(SLOT_COUNT);

        sx    = i_arg[15:8];
        sy    = i_arg[7:0];
        cur_w = (i_cmd == fcrp_pkg::CMD_ASCII_SIZE) ? r_ascii_w : r_kanji_w;
        cur_h = (i_cmd == fcrp_pkg::CMD_ASCII_SIZE) ? r_ascii_h : r_kanji_h;

        n_ascii_w = r_ascii_w;
        n_ascii_h = r_ascii_h;
        n_kanji_w = r_kanji_w;
        n_kanji_h = r_kanji_h;
        n_halted  = r_halted;

        o_entry.is_start   = 1'b0;
        o_entry.slot_write = 1'b0;
        o_entry.status     = fcrp_pkg::STS_HALTED;
        o_entry.slot       = 16'd0;
        o_entry.glyph_ref  = 32'd0;

        if (i_cmd == fcrp_pkg::CMD_START) begin
            o_entry.is_start = 1'b1;
            o_entry.status   = fcrp_pkg::STS_STARTED;
            n_ascii_w = 8'd0;
            n_ascii_h = 8'd0;
            n_kanji_w = 8'd0;
            n_kanji_h = 8'd0;
            n_halted  = 1'b0;
        end else if (r_halted) begin
            o_entry.status = fcrp_pkg::STS_HALTED;
        end else if (i_record_len < 16'(fcrp_pkg::HEADER_BYTES)) begin
            o_entry.status = fcrp_pkg::STS_SHORT_RECORD;
            n_halted = 1'b1;
        end else begin
            case (i_cmd)
                fcrp_pkg::CMD_SET_GLYPH: begin
                    if (sel_w == 8'd0 || sel_h == 8'd0) begin
                        o_entry.status = fcrp_pkg::STS_SIZE_UNDEF;
                        n_halted = 1'b1;
                    end else if (payload_short) begin
                        o_entry.status = fcrp_pkg::STS_PAYLOAD_SHORT;
                        n_halted = 1'b1;
                    end else if ((!single && !jis_ok) || !code_fits) begin
                        o_entry.status = fcrp_pkg::STS_CODE_IGNORED;
                    end else begin
                        o_entry.status     = fcrp_pkg::STS_GLYPH_STORED;
                        o_entry.slot_write = 1'b1;
                        o_entry.slot       = code;
                        o_entry.glyph_ref  = i_glyph_ref;
                    end
                end
                fcrp_pkg::CMD_ASCII_SIZE, fcrp_pkg::CMD_KANJI_SIZE: begin
                    if (sx == 8'd0 || sy == 8'd0) begin
                        o_entry.status = fcrp_pkg::STS_ZERO_SIZE;
                        n_halted = 1'b1;
                    end else if ((cur_w != 8'd0 && cur_w != sx)
                                 || (cur_h != 8'd0 && cur_h != sy)) begin
                        o_entry.status = fcrp_pkg::STS_SIZE_CONFLICT;
                        n_halted = 1'b1;
                    end else begin
                        o_entry.status = fcrp_pkg::STS_SIZE_SET;
                        if (i_cmd == fcrp_pkg::CMD_ASCII_SIZE) begin
                            n_ascii_w = sx;
                            n_ascii_h = sy;
                        end else begin
                            n_kanji_w = sx;
                            n_kanji_h = sy;
                        end
                    end
                end
                default: begin
                    o_entry.status = fcrp_pkg::STS_BAD_COMMAND;
                    n_halted = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii_w <= 8'd0;
            r_ascii_h <= 8'd0;
            r_kanji_w <= 8'd0;
            r_kanji_h <= 8'd0;
            r_halted  <= 1'b0;
        end else if (o_push) begin
            r_ascii_w <= n_ascii_w;
            r_ascii_h <= n_ascii_h;
            r_kanji_w <= n_kanji_w;
            r_kanji_h <= n_kanji_h;
            r_halted  <= n_halted;
        end
    end

endmodule

@@ rtl/fcrp_back.sv @@
`timescale 1ns / 1ps
// Back part: read-modify-write of the slot-used bitmap, clearing pass after
// reset and start, and the output register. Depends on fcrp_pkg, fcrp_ram.
module fcrp_back #(
    parameter int SLOT_COUNT = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  fcrp_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [3:0]       o_status,
    output logic [15:0]      o_slot,
    output logic             o_slot_write,
    output logic             o_overridden,
    output logic [31:0]      o_glyph_ref_out
);

    localparam int AW = $clog2(SLOT_COUNT);

    typedef enum logic {S_CLEAR, S_RUN} t_state;

    t_state           r_state;
    logic [AW-1:0]    r_clr;
    logic             r_busy;
    fcrp_pkg::t_entry r_cur;
    logic             r_out_valid;
    logic             out_free;
    logic             finish;
    logic             we;
    logic [AW-1:0]    waddr;
    logic             wdata;
    logic             used;

    fcrp_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_used (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (o_pop),
        .i_raddr(i_entry.slot[AW-1:0]),
        .o_rdata(used)
    );

    assign out_free = ~r_out_valid | i_ready;
    assign o_pop    = (r_state == S_RUN) & ~r_busy & ~i_q_empty;
    assign finish   = (r_state == S_RUN) & r_busy & out_free;

    always_comb begin
        if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = 1'b0;
        end else begin
            we    = finish & r_cur.slot_write;
            waddr = r_cur.slot[AW-1:0];
            wdata = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(SLOT_COUNT - 1)) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (o_pop) begin
                        r_busy <= 1'b1;
                        r_cur  <= i_entry;
                    end
                    if (finish) begin
                        r_busy          <= 1'b0;
                        o_status        <= r_cur.status;
                        o_slot          <= r_cur.slot;
                        o_slot_write    <= r_cur.slot_write;
                        o_overridden    <= r_cur.slot_write & used;
                        o_glyph_ref_out <= r_cur.glyph_ref;
                        // A start clears the bitmap before the next record.
                        if (r_cur.is_start) begin
                            r_state <= S_CLEAR;
                            r_clr   <= '0;
                        end
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ rtl/font_command_record_parser.sv @@
`timescale 1ns / 1ps
// Top level of the font command record parser.
// Depends on fcrp_pkg, fcrp_front, fcrp_queue, fcrp_back.
//
//  Channel  Direction  Handshake            Payload
//  input    in         i_valid / o_ready    i_cmd, i_arg, i_record_len, i_glyph_ref
//  result   out        o_valid / i_ready    o_status, o_slot, o_slot_write,
//                                           o_overridden, o_glyph_ref_out
//
// In the back part each record first reads the slot-used bitmap RAM, then
// writes it back and loads the result register once that register is free.
// After reset and after every start record the back part clears every entry
// of the bitmap; records keep being taken until the two-entry queue fills.
// The front part stalls only on a full queue; the result register holds while
// i_ready is low.
module font_command_record_parser #(
    parameter int SLOT_COUNT = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_arg,
    input  logic [15:0] i_record_len,
    input  logic [31:0] i_glyph_ref,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status,
    output logic [15:0] o_slot,
    output logic        o_slot_write,
    output logic        o_overridden,
    output logic [31:0] o_glyph_ref_out
);

    fcrp_pkg::t_entry push_entry, head_entry;
    logic             push, pop, q_full, q_empty;

    fcrp_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_arg       (i_arg),
        .i_record_len(i_record_len),
        .i_glyph_ref (i_glyph_ref),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    fcrp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_entry),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_data (head_entry)
    );

    fcrp_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_entry        (head_entry),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_slot_write   (o_slot_write),
        .o_overridden   (o_overridden),
        .o_glyph_ref_out(o_glyph_ref_out)
    );

endmodule

@@ rtl/fcrp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the font command record parser, bound to the top.
// Depends on fcrp_pkg and font_command_record_parser.
module fcrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_status,
    input logic [15:0] o_slot,
    input logic        o_slot_write,
    input logic        o_overridden,
    input logic [31:0] o_glyph_ref_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_slot_write == (o_status == fcrp_pkg::STS_GLYPH_STORED)))
        else $error("slot write disagrees with status");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_slot_write |->
            !o_overridden && o_slot == 16'd0 && o_glyph_ref_out == 32'd0)
        else $error("fields set without a slot write");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind font_command_record_parser fcrp_checker u_fcrp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_slot         (o_slot),
    .o_slot_write   (o_slot_write),
    .o_overridden   (o_overridden),
    .o_glyph_ref_out(o_glyph_ref_out)
);
